FILE: design/scba_pkg.sv
package scba_pkg;

    // Fixed geometry of the bus and the input transaction.
    localparam int NUM_REQ        = 5;
    localparam int REQ_BITS       = 3;
    localparam int IDX_BITS       = $clog2(NUM_REQ);
    localparam int IN_COUNT_BITS  = 8;
    localparam int COUNT_BITS_DEF = 8;

    // Only counts strictly below this limit are eligible for a grant.
    localparam int SJF_LIMIT      = 129;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic log;
        logic scan;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_needed;
        logic scan_last;
    } t_dp_sts;

    // One-hot grant line pattern for a device number; zero gives no line.
    function automatic logic [NUM_REQ-1:0] one_hot(input logic [REQ_BITS-1:0] dev);
        logic [NUM_REQ-1:0] v;
        v = '0;
        for (int i = 0; i < NUM_REQ; i++) begin
            if (dev == REQ_BITS'(i + 1)) begin
                v[i] = 1'b1;
            end
        end
        return v;
    endfunction

endpackage

FILE: design/shortest_count_bus_arbiter_unit.sv
// Shortest-count bus arbiter for five requesters. A transaction is taken at a
// clock edge with start high and busy low; its result appears on the o_ result
// ports for exactly one cycle with o_valid high, and the receiver cannot stall
// it. A new transaction is taken only after busy falls. When an owner holds or
// releases the bus, a transaction passes through the log and finish states;
// when the arbiter is idle it also passes through the scan state, in which the
// datapath compares one pending requester per cycle against the running
// minimum. The result strobe comes in the cycle in which busy falls. Counts
// below 129 are eligible and ties go to the lower device number.
module shortest_count_bus_arbiter_unit #(
    parameter int COUNT_BITS = scba_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [scba_pkg::REQ_BITS-1:0]      i_requester,
    input  logic [scba_pkg::IN_COUNT_BITS-1:0] i_byte_count,
    input  logic [scba_pkg::NUM_REQ-1:0]       i_request_lines,
    output logic                               o_valid,
    output logic [scba_pkg::REQ_BITS-1:0]      o_grant_owner,
    output logic [scba_pkg::NUM_REQ-1:0]       o_grant_lines,
    output logic                               o_lines_driven,
    output logic                               o_bad_requester
);
    import scba_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer.
    scba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Arbiter state and result registers.
    scba_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_requester     (i_requester),
        .i_byte_count    (i_byte_count),
        .i_request_lines (i_request_lines),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_grant_owner   (o_grant_owner),
        .o_grant_lines   (o_grant_lines),
        .o_lines_driven  (o_lines_driven),
        .o_bad_requester (o_bad_requester)
    );

endmodule

FILE: design/scba_datapath.sv
module scba_datapath #(
    parameter int COUNT_BITS = scba_pkg::COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  scba_pkg::t_dp_cmd                    i_cmd,
    input  logic [scba_pkg::REQ_BITS-1:0]        i_requester,
    input  logic [scba_pkg::IN_COUNT_BITS-1:0]   i_byte_count,
    input  logic [scba_pkg::NUM_REQ-1:0]         i_request_lines,
    output scba_pkg::t_dp_sts                    o_sts,
    output logic                                 o_valid,
    output logic [scba_pkg::REQ_BITS-1:0]        o_grant_owner,
    output logic [scba_pkg::NUM_REQ-1:0]         o_grant_lines,
    output logic                                 o_lines_driven,
    output logic                                 o_bad_requester
);
    import scba_pkg::*;

    // Compare width covers both the logged counts and the eligibility limit.
    localparam int CMP_BITS = (COUNT_BITS > IN_COUNT_BITS) ? COUNT_BITS : IN_COUNT_BITS;

    // Captured transaction.
    logic [REQ_BITS-1:0]   r_req;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [NUM_REQ-1:0]    r_lines;

    // Arbiter state.
    logic [COUNT_BITS-1:0] r_counts [NUM_REQ];
    logic [NUM_REQ-1:0]    r_pend;
    logic [REQ_BITS-1:0]   r_owner;
    logic [NUM_REQ-1:0]    r_held;

    // Scan working registers.
    logic [CMP_BITS-1:0]   r_best;
    logic [REQ_BITS-1:0]   r_pick;
    logic [IDX_BITS-1:0]   r_idx;
    logic                  r_bad;

    // Result registers.
    logic                  r_valid;
    logic [REQ_BITS-1:0]   r_out_owner;
    logic [NUM_REQ-1:0]    r_out_lines;
    logic                  r_out_driven;
    logic                  r_out_bad;

    logic                  w_req_ok;
    logic [IDX_BITS-1:0]   w_req_idx;
    logic [IDX_BITS-1:0]   w_own_idx;
    logic                  w_release;
    logic [CMP_BITS-1:0]   w_scan_cnt;
    logic                  w_better;
    logic [REQ_BITS-1:0]   w_new_owner;
    logic                  w_drive;

    // Requester decode and release check on the captured transaction.
    assign w_req_ok  = (r_req != '0) && (r_req <= REQ_BITS'(NUM_REQ));
    assign w_req_idx = IDX_BITS'(r_req - 1'b1);
    assign w_own_idx = IDX_BITS'(r_owner - 1'b1);
    assign w_release = (r_owner != '0) && !r_lines[w_own_idx];

    // One requester is compared against the running minimum per scan cycle.
    assign w_scan_cnt = CMP_BITS'(r_counts[r_idx]);
    assign w_better   = r_pend[r_idx] && (w_scan_cnt < r_best);

    // After release the pick is zero, so the owner ends up cleared.
    assign w_new_owner = (r_owner == '0) ? r_pick : r_owner;
    assign w_drive     = (w_new_owner != '0);

    assign o_sts.scan_needed = (r_owner == '0);
    assign o_sts.scan_last   = (r_idx == IDX_BITS'(NUM_REQ - 1));

    assign o_valid         = r_valid;
    assign o_grant_owner   = r_out_owner;
    assign o_grant_lines   = r_out_lines;
    assign o_lines_driven  = r_out_driven;
    assign o_bad_requester = r_out_bad;

    // Transaction capture, logging, scan and result update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REQ; i++) begin
                r_counts[i] <= '0;
            end
            r_pend  <= '0;
            r_owner <= '0;
            r_held  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;

            if (i_cmd.load) begin
                r_req   <= i_requester;
                r_cnt   <= COUNT_BITS'(CMP_BITS'(i_byte_count));
                r_lines <= i_request_lines;
            end

            // Log the count first; a release of the same device wins on its mark.
            if (i_cmd.log) begin
                r_bad  <= !w_req_ok;
                r_best <= CMP_BITS'(SJF_LIMIT);
                r_pick <= '0;
                r_idx  <= '0;
                if (w_req_ok) begin
                    r_counts[w_req_idx] <= r_cnt;
                    r_pend[w_req_idx]   <= 1'b1;
                end
                if (w_release) begin
                    r_pend[w_own_idx] <= 1'b0;
                    r_owner           <= '0;
                end
            end

            // Strict less-than keeps the lower device number on ties.
            if (i_cmd.scan) begin
                if (w_better) begin
                    r_best <= w_scan_cnt;
                    r_pick <= REQ_BITS'(r_idx) + 1'b1;
                end
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.finish) begin
                r_owner      <= w_new_owner;
                r_out_owner  <= w_new_owner;
                r_out_driven <= w_drive;
                r_out_bad    <= r_bad;
                if (w_drive) begin
                    r_held      <= one_hot(w_new_owner);
                    r_out_lines <= one_hot(w_new_owner);
                end else begin
                    r_out_lines <= r_held;
                end
            end
        end
    end

endmodule

FILE: design/scba_ctrl.sv
module scba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  scba_pkg::t_dp_sts i_sts,
    output scba_pkg::t_dp_cmd o_cmd
);
    import scba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOG,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                n_state = i_sts.scan_needed ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands decoded from the state.
    assign busy         = (r_state != S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && start;
    assign o_cmd.log    = (r_state == S_LOG);
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.finish = (r_state == S_FIN);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import scba_pkg::*;

    localparam logic [REQ_BITS-1:0] NO_OWNER       = '0;
    localparam int                  WATCHDOG_LIMIT = 2000;
    localparam int                  RANDOM_ITEMS   = 400;
    localparam int                  DRAIN_CYCLES   = 20;

    // One result transaction as it leaves the arbiter.
    typedef struct packed {
        logic [REQ_BITS-1:0] owner;
        logic [NUM_REQ-1:0]  lines;
        logic                driven;
        logic                bad;
    } t_grant;

    // One directed transaction; typed rows carry their own expected result.
    typedef struct packed {
        logic [REQ_BITS-1:0]      req;
        logic [IN_COUNT_BITS-1:0] cnt;
        logic [NUM_REQ-1:0]       lines;
        bit                       typed;
        t_grant                   want;
    } t_stim_row;

    localparam int NUM_ROWS = 22;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [REQ_BITS-1:0]      i_requester;
    logic [IN_COUNT_BITS-1:0] i_byte_count;
    logic [NUM_REQ-1:0]       i_request_lines;
    logic                     o_valid;
    logic [REQ_BITS-1:0]      o_grant_owner;
    logic [NUM_REQ-1:0]       o_grant_lines;
    logic                     o_lines_driven;
    logic                     o_bad_requester;

    // Shadow copy of the arbiter state.
    logic [IN_COUNT_BITS-1:0] log_count [NUM_REQ] = '{default: '0};
    bit                       log_pending [NUM_REQ] = '{default: 1'b0};
    logic [REQ_BITS-1:0]      gnt_owner = NO_OWNER;
    logic [NUM_REQ-1:0]       gnt_held = '0;

    t_grant owed_grants [$];
    int     mismatches = 0;
    int     idle_cycles = 0;

    // Directed walk: invalid ids, the eligibility limit, ties, holds and releases.
    t_stim_row dir_rows [NUM_ROWS] = '{
        '{3'd0, 8'd0,   5'h00, 1'b1, '{3'd0, 5'h00, 1'b0, 1'b1}},
        '{3'd7, 8'd255, 5'h1f, 1'b1, '{3'd0, 5'h00, 1'b0, 1'b1}},
        '{3'd3, 8'd200, 5'h00, 1'b1, '{3'd0, 5'h00, 1'b0, 1'b0}},
        '{3'd2, 8'd129, 5'h1f, 1'b1, '{3'd0, 5'h00, 1'b0, 1'b0}},
        '{3'd5, 8'd128, 5'h10, 1'b1, '{3'd5, 5'h10, 1'b1, 1'b0}},
        '{3'd1, 8'd0,   5'h10, 1'b0, '0},
        '{3'd4, 8'd0,   5'h0f, 1'b1, '{3'd0, 5'h10, 1'b0, 1'b0}},
        '{3'd0, 8'd0,   5'h00, 1'b1, '{3'd1, 5'h01, 1'b1, 1'b1}},
        '{3'd6, 8'd77,  5'h00, 1'b0, '0},
        '{3'd0, 8'd0,   5'h00, 1'b0, '0},
        '{3'd4, 8'd255, 5'h08, 1'b0, '0},
        '{3'd2, 8'd1,   5'h00, 1'b0, '0},
        '{3'd3, 8'd1,   5'h1f, 1'b0, '0},
        '{3'd1, 8'd127, 5'h02, 1'b0, '0},
        '{3'd5, 8'd0,   5'h1d, 1'b0, '0},
        '{3'd0, 8'd0,   5'h00, 1'b0, '0},
        '{3'd5, 8'd255, 5'h00, 1'b0, '0},
        '{3'd0, 8'd0,   5'h00, 1'b0, '0},
        '{3'd3, 8'd130, 5'h00, 1'b0, '0},
        '{3'd0, 8'd0,   5'h00, 1'b0, '0},
        '{3'd1, 8'd128, 5'h01, 1'b0, '0},
        '{3'd1, 8'd0,   5'h00, 1'b0, '0}
    };

    shortest_count_bus_arbiter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_requester     (i_requester),
        .i_byte_count    (i_byte_count),
        .i_request_lines (i_request_lines),
        .o_valid         (o_valid),
        .o_grant_owner   (o_grant_owner),
        .o_grant_lines   (o_grant_lines),
        .o_lines_driven  (o_lines_driven),
        .o_bad_requester (o_bad_requester)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Log the count, then release or arbitrate, and return the grant state.
    function automatic t_grant arbitrate(input logic [REQ_BITS-1:0] req,
                                         input logic [IN_COUNT_BITS-1:0] cnt,
                                         input logic [NUM_REQ-1:0] lines);
        t_grant              g;
        int                  best;
        logic [REQ_BITS-1:0] pick;
        g = '0;
        if (req >= 1 && req <= NUM_REQ) begin
            log_count[req-1]   = cnt;
            log_pending[req-1] = 1'b1;
        end else begin
            g.bad = 1'b1;
        end
        if (gnt_owner != NO_OWNER && !lines[gnt_owner-1]) begin
            log_pending[gnt_owner-1] = 1'b0;
            gnt_owner                = NO_OWNER;
        end else if (gnt_owner == NO_OWNER) begin
            best = SJF_LIMIT;
            pick = NO_OWNER;
            for (int i = 0; i < NUM_REQ; i++) begin
                if (log_pending[i] && int'(log_count[i]) < best) begin
                    best = int'(log_count[i]);
                    pick = REQ_BITS'(i + 1);
                end
            end
            if (pick != NO_OWNER) begin
                gnt_owner = pick;
                gnt_held  = NUM_REQ'(1) << (pick - 1);
                g.driven  = 1'b1;
            end
        end else begin
            gnt_held = NUM_REQ'(1) << (gnt_owner - 1);
            g.driven = 1'b1;
        end
        g.owner = gnt_owner;
        g.lines = gnt_held;
        return g;
    endfunction

    // Present one transaction, wait for it to be taken, and record what it owes.
    task automatic issue(input logic [REQ_BITS-1:0] req,
                         input logic [IN_COUNT_BITS-1:0] cnt,
                         input logic [NUM_REQ-1:0] lines,
                         input bit typed,
                         input t_grant want);
        t_grant g;
        start           <= 1'b1;
        i_requester     <= req;
        i_byte_count    <= cnt;
        i_request_lines <= lines;
        do @(posedge i_clk); while (busy !== 1'b0);
        g = arbitrate(req, cnt, lines);
        owed_grants.push_back(typed ? want : g);
    endtask

    // Stimulus: reset, the directed table, then bursts of random transactions.
    initial begin : stimulus
        int                       burst_left;
        int                       gap;
        logic [REQ_BITS-1:0]      req;
        logic [IN_COUNT_BITS-1:0] cnt;
        logic [NUM_REQ-1:0]       lines;
        int                       sel;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_requester     <= '0;
        i_byte_count    <= '0;
        i_request_lines <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            issue(dir_rows[k].req, dir_rows[k].cnt, dir_rows[k].lines,
                  dir_rows[k].typed, dir_rows[k].want);
            if (k % 3 == 2 && k % 5 != 0) begin
                start <= 1'b0;
                repeat (k % 5) @(posedge i_clk);
            end
        end

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Mostly valid ids, with the odd out-of-range one.
            if ($urandom_range(0, 9) != 0) begin
                req = REQ_BITS'($urandom_range(1, NUM_REQ));
            end else begin
                sel = $urandom_range(0, 2);
                req = (sel == 0) ? REQ_BITS'(0) : REQ_BITS'(sel + 5);
            end
            // Spread counts around the eligibility limit and across the range.
            case ($urandom_range(0, 3))
                0: cnt = IN_COUNT_BITS'($urandom_range(0, 128));
                1: cnt = IN_COUNT_BITS'($urandom_range(129, 255));
                2: cnt = IN_COUNT_BITS'($urandom_range(120, 135));
                default: cnt = IN_COUNT_BITS'($urandom_range(0, 255));
            endcase
            // The owner usually keeps its line up so grants last a while.
            lines = NUM_REQ'($urandom_range(0, 31));
            if (gnt_owner != NO_OWNER && $urandom_range(0, 3) != 0) begin
                lines[gnt_owner-1] = 1'b1;
            end
            issue(req, cnt, lines, 1'b0, '0);

            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
        start <= 1'b0;

        while (owed_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Compare each result transaction with the oldest owed grant.
    always @(posedge i_clk) begin : check
        t_grant want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (owed_grants.size() == 0) begin
                $error("unexpected result transaction: owner %0d", o_grant_owner);
                mismatches++;
            end else begin
                want = owed_grants.pop_front();
                if (o_grant_owner !== want.owner) begin
                    $error("grant_owner: expected %0d, got %0d", want.owner, o_grant_owner);
                    mismatches++;
                end
                if (o_grant_lines !== want.lines) begin
                    $error("grant_lines: expected %b, got %b", want.lines, o_grant_lines);
                    mismatches++;
                end
                if (o_lines_driven !== want.driven) begin
                    $error("lines_driven: expected %b, got %b", want.driven, o_lines_driven);
                    mismatches++;
                end
                if (o_bad_requester !== want.bad) begin
                    $error("bad_requester: expected %b, got %b", want.bad, o_bad_requester);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with neither an input nor a result transaction.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: sim.f
design/scba_pkg.sv
design/scba_datapath.sv
design/scba_ctrl.sv
design/shortest_count_bus_arbiter_unit.sv
dv/tb.sv
